// ===== src/wscm_pkg.sv =====
// ----------------------------------------------------------------------------
// wscm_pkg
// Shared widths, codes, structs and the restoring-division step used by the
// wallpaper source coordinate mapper.
// ----------------------------------------------------------------------------
package wscm_pkg;

    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int NUM_W       = 2 * DIM_W;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_DIM_DEF = 4096;

    localparam logic [MODE_W-1:0] MODE_STRETCH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TILE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CENTER  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIT     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FILL    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd4;

    // Per-axis mapping: window [lo, lo+len), then ((p-lo)*mul)/den or the
    // remainder, plus add, clamped below lim.
    typedef struct packed {
        logic [DIM_W-1:0] lo;
        logic [DIM_W-1:0] len;
        logic [DIM_W-1:0] mul;
        logic [DIM_W-1:0] den;
        logic [DIM_W-1:0] add;
        logic [DIM_W-1:0] lim;
        logic             use_rem;
    } t_axis;

    typedef struct packed {
        logic  ready;
        logic  zero;
        t_axis ax;
        t_axis ay;
    } t_geom;

    typedef struct packed {
        logic             valid;
        logic             cov;
        logic [NUM_W-1:0] acc_x;
        logic [DIM_W-1:0] rem_x;
        logic [NUM_W-1:0] acc_y;
        logic [DIM_W-1:0] rem_y;
    } t_lane;

    // One restoring-division step: returns {quotient bit, new remainder}.
    function automatic logic [DIM_W:0] div_step(input logic [DIM_W-1:0] rem,
                                                input logic             bit_in,
                                                input logic [DIM_W-1:0] den);
        logic [DIM_W:0] trial;
        logic [DIM_W:0] diff;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            return {1'b1, diff[DIM_W-1:0]};
        end
        return {1'b0, trial[DIM_W-1:0]};
    endfunction

endpackage

// ===== src/wscm_pix_if.sv =====
// ----------------------------------------------------------------------------
// wscm_pix_if
// Desktop pixel coordinate channel.
// ----------------------------------------------------------------------------
interface wscm_pix_if;
    logic                         valid;
    logic                         ready;
    logic [wscm_pkg::COORD_W-1:0] pixel_x;
    logic [wscm_pkg::COORD_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== src/wscm_src_if.sv =====
// ----------------------------------------------------------------------------
// wscm_src_if
// Wallpaper source coordinate channel.
// ----------------------------------------------------------------------------
interface wscm_src_if;
    logic                         valid;
    logic                         ready;
    logic [wscm_pkg::COORD_W-1:0] src_x;
    logic [wscm_pkg::COORD_W-1:0] src_y;
    logic                         covered;

    modport source (output valid, output src_x, output src_y, output covered, input ready);
    modport sink   (input valid, input src_x, input src_y, input covered, output ready);
endinterface

// ===== src/wallpaper_source_coordinate_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// wallpaper_source_coordinate_mapper_unit
// Maps desktop pixel coordinates to nearest-neighbor wallpaper coordinates.
// ----------------------------------------------------------------------------
// Desktop coordinates arrive as beats on i_pix; one result beat per input
// leaves on o_src carrying src_x, src_y and the covered flag. The user must
// write registers through i_cfg_we / i_cfg_idx / i_cfg_data only while no
// beat is in flight; the block itself does not enforce this.
// Throughput is one beat per clock while the receiver is not stalling and
// the geometry unit is ready. A beat passes a window check stage, a multiply
// stage, one division cell per quotient bit and the output register.
// After reset and after every register write the geometry unit recomputes
// the mapping with a bit-serial divider, loading and dividing each of the
// four ratios in turn and then finishing; i_pix.ready stays low meanwhile.
// A stalled receiver freezes the whole chain, and i_pix.ready drops in the
// same cycle, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module wallpaper_source_coordinate_mapper_unit #(
    parameter int MAX_DIM = wscm_pkg::MAX_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wscm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wscm_pkg::DIM_W-1:0]     i_cfg_data,
    wscm_pix_if.sink                       i_pix,
    wscm_src_if.source                     o_src
);

    localparam int DW = wscm_pkg::DIM_W;
    localparam int NW = wscm_pkg::NUM_W;
    localparam int CW = wscm_pkg::COORD_W;

    wscm_pkg::t_geom w_geom;
    wscm_pkg::t_lane w_lane [NW+1];
    wscm_pkg::t_lane w_last;

    logic          w_en;
    logic [DW-1:0] w_px, w_py, w_dx, w_dy;
    logic          w_in_win;

    logic          r_a_valid, r_a_cov;
    logic [CW-1:0] r_a_offx, r_a_offy;
    wscm_pkg::t_lane r_b_lane;

    logic [NW-1:0] w_valx, w_valy;
    logic [NW:0]   w_sumx, w_sumy;
    logic [CW-1:0] w_resx, w_resy;

    logic          r_out_valid, r_out_cov;
    logic [CW-1:0] r_out_x, r_out_y;

    wscm_geom #(.MAX_DIM(MAX_DIM)) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (w_geom)
    );

    assign w_en        = !r_out_valid || o_src.ready;
    assign i_pix.ready = w_en && w_geom.ready;

    assign w_px     = {1'b0, i_pix.pixel_x};
    assign w_py     = {1'b0, i_pix.pixel_y};
    assign w_dx     = w_px - w_geom.ax.lo;
    assign w_dy     = w_py - w_geom.ay.lo;
    assign w_in_win = !w_geom.zero
                      && (w_px >= w_geom.ax.lo) && (w_dx < w_geom.ax.len)
                      && (w_py >= w_geom.ay.lo) && (w_dy < w_geom.ay.len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid      <= 1'b0;
            r_b_lane.valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_pix.valid && i_pix.ready;
            r_a_cov   <= w_in_win;
            r_a_offx  <= w_dx[CW-1:0];
            r_a_offy  <= w_dy[CW-1:0];

            r_b_lane.valid <= r_a_valid;
            r_b_lane.cov   <= r_a_cov;
            r_b_lane.acc_x <= NW'(r_a_offx) * NW'(w_geom.ax.mul);
            r_b_lane.acc_y <= NW'(r_a_offy) * NW'(w_geom.ay.mul);
            r_b_lane.rem_x <= '0;
            r_b_lane.rem_y <= '0;
        end
    end

    assign w_lane[0] = r_b_lane;

    for (genvar g = 0; g < NW; g++) begin : g_cell
        wscm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_den_x (w_geom.ax.den),
            .i_den_y (w_geom.ay.den),
            .i_lane  (w_lane[g]),
            .o_lane  (w_lane[g+1])
        );
    end

    assign w_last = w_lane[NW];

    assign w_valx = w_geom.ax.use_rem ? NW'(w_last.rem_x) : w_last.acc_x;
    assign w_valy = w_geom.ay.use_rem ? NW'(w_last.rem_y) : w_last.acc_y;
    assign w_sumx = (NW+1)'(w_valx) + (NW+1)'(w_geom.ax.add);
    assign w_sumy = (NW+1)'(w_valy) + (NW+1)'(w_geom.ay.add);

    always_comb begin
        w_resx = w_sumx[CW-1:0];
        w_resy = w_sumy[CW-1:0];
        if (w_sumx >= (NW+1)'(w_geom.ax.lim)) begin
            w_resx = CW'(w_geom.ax.lim - DW'(1));
        end
        if (w_sumy >= (NW+1)'(w_geom.ay.lim)) begin
            w_resy = CW'(w_geom.ay.lim - DW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
            r_out_cov   <= w_last.cov;
            r_out_x     <= w_last.cov ? w_resx : '0;
            r_out_y     <= w_last.cov ? w_resy : '0;
        end
    end

    assign o_src.valid   = r_out_valid;
    assign o_src.src_x   = r_out_x;
    assign o_src.src_y   = r_out_y;
    assign o_src.covered = r_out_cov;

endmodule

// ===== src/wscm_geom.sv =====
// ----------------------------------------------------------------------------
// wscm_geom
// Holds the configuration registers and derives the per-axis mapping after
// reset and after every register write, using a bit-serial divider.
// ----------------------------------------------------------------------------
module wscm_geom #(
    parameter int MAX_DIM = wscm_pkg::MAX_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wscm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wscm_pkg::DIM_W-1:0]     i_cfg_data,
    output wscm_pkg::t_geom                o_geom
);

    localparam int DW    = wscm_pkg::DIM_W;
    localparam int NW    = wscm_pkg::NUM_W;
    localparam int CNT_W = $clog2(NW);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state                        r_state;
    logic [wscm_pkg::MODE_W-1:0]   r_mode;
    logic [DW-1:0]                 r_iw, r_ih, r_sw, r_sh;
    logic [1:0]                    r_sel;
    logic [CNT_W-1:0]              r_cnt;
    logic [NW-1:0]                 r_acc;
    logic [DW-1:0]                 r_rem;
    logic [DW-1:0]                 r_quo [4];
    logic                          r_zero;
    wscm_pkg::t_axis               r_ax, r_ay;
    wscm_pkg::t_axis               n_ax, n_ay;

    logic [DW-1:0] w_iw, w_ih, w_sw, w_sh;
    logic [DW-1:0] w_a, w_b, w_den;
    logic [DW:0]   w_step;
    logic [DW-1:0] w_th0, w_tw, w_th, w_cw, w_ch, w_x0, w_y0;

    function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] v);
        if (32'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end
        return v;
    endfunction

    function automatic logic [DW-1:0] at_least_one(input logic [DW-1:0] v);
        return (v == '0) ? DW'(1) : v;
    endfunction

    function automatic logic [DW-1:0] centre_off(input logic [DW-1:0] outer,
                                                 input logic [DW-1:0] inner);
        logic [DW-1:0] diff;
        diff = outer - inner;
        return (outer > inner) ? (diff >> 1) : '0;
    endfunction

    assign w_iw = sat_dim(r_iw);
    assign w_ih = sat_dim(r_ih);
    assign w_sw = sat_dim(r_sw);
    assign w_sh = sat_dim(r_sh);

    // The four cross ratios that fit and fill need.
    always_comb begin
        unique case (r_sel)
            2'd0: begin w_a = w_sw; w_b = w_ih; w_den = w_iw; end
            2'd1: begin w_a = w_sh; w_b = w_iw; w_den = w_ih; end
            2'd2: begin w_a = w_ih; w_b = w_sw; w_den = w_sh; end
            default: begin w_a = w_iw; w_b = w_sh; w_den = w_sw; end
        endcase
    end

    assign w_step = wscm_pkg::div_step(r_rem, r_acc[NW-1], w_den);

    always_comb begin
        w_th0 = at_least_one(r_quo[0]);
        if (w_th0 > w_sh) begin
            w_th = w_sh;
            w_tw = at_least_one(r_quo[1]);
        end else begin
            w_th = w_th0;
            w_tw = w_sw;
        end

        w_cw = w_iw;
        w_ch = w_ih;
        w_x0 = '0;
        w_y0 = '0;
        if (w_th0 < w_sh) begin
            w_cw = at_least_one(r_quo[2]);
            w_x0 = centre_off(w_iw, w_cw);
        end else if (w_th0 > w_sh) begin
            w_ch = at_least_one(r_quo[3]);
            w_y0 = centre_off(w_ih, w_ch);
        end

        n_ax = '{lo: '0, len: w_sw, mul: w_cw, den: w_sw, add: w_x0,
                 lim: w_iw, use_rem: 1'b0};
        n_ay = '{lo: '0, len: w_sh, mul: w_ch, den: w_sh, add: w_y0,
                 lim: w_ih, use_rem: 1'b0};
        case (r_mode)
            wscm_pkg::MODE_STRETCH: begin
                n_ax.mul = w_iw;
                n_ay.mul = w_ih;
                n_ax.add = '0;
                n_ay.add = '0;
            end
            wscm_pkg::MODE_TILE: begin
                n_ax.mul = DW'(1);
                n_ay.mul = DW'(1);
                n_ax.den = w_iw;
                n_ay.den = w_ih;
                n_ax.add = '0;
                n_ay.add = '0;
                n_ax.use_rem = 1'b1;
                n_ay.use_rem = 1'b1;
            end
            wscm_pkg::MODE_CENTER: begin
                n_ax.len = (w_iw < w_sw) ? w_iw : w_sw;
                n_ay.len = (w_ih < w_sh) ? w_ih : w_sh;
                n_ax.lo  = centre_off(w_sw, n_ax.len);
                n_ay.lo  = centre_off(w_sh, n_ay.len);
                n_ax.mul = DW'(1);
                n_ay.mul = DW'(1);
                n_ax.den = DW'(1);
                n_ay.den = DW'(1);
                n_ax.add = centre_off(w_iw, w_sw);
                n_ay.add = centre_off(w_ih, w_sh);
            end
            wscm_pkg::MODE_FIT: begin
                n_ax.len = w_tw;
                n_ay.len = w_th;
                n_ax.lo  = centre_off(w_sw, w_tw);
                n_ay.lo  = centre_off(w_sh, w_th);
                n_ax.mul = w_iw;
                n_ay.mul = w_ih;
                n_ax.den = w_tw;
                n_ay.den = w_th;
                n_ax.add = '0;
                n_ay.add = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_mode  <= wscm_pkg::MODE_STRETCH;
            r_iw    <= DW'(1);
            r_ih    <= DW'(1);
            r_sw    <= DW'(1);
            r_sh    <= DW'(1);
            r_sel   <= '0;
            r_cnt   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wscm_pkg::CFG_SCALE_MODE:    r_mode <= i_cfg_data[wscm_pkg::MODE_W-1:0];
                wscm_pkg::CFG_IMAGE_WIDTH:   r_iw   <= i_cfg_data;
                wscm_pkg::CFG_IMAGE_HEIGHT:  r_ih   <= i_cfg_data;
                wscm_pkg::CFG_SCREEN_WIDTH:  r_sw   <= i_cfg_data;
                wscm_pkg::CFG_SCREEN_HEIGHT: r_sh   <= i_cfg_data;
                default: begin
                end
            endcase
            r_state <= ST_LOAD;
            r_sel   <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    r_acc   <= NW'(w_a) * NW'(w_b);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_acc <= {r_acc[NW-2:0], w_step[DW]};
                    r_rem <= w_step[DW-1:0];
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NW - 1)) begin
                        // Ratios beyond the dimension range only feed compares.
                        r_quo[r_sel] <= (|r_acc[NW-2:DW-1]) ? '1
                                        : {r_acc[DW-2:0], w_step[DW]};
                        r_sel        <= r_sel + 2'd1;
                        r_state      <= (r_sel == 2'd3) ? ST_FIN : ST_LOAD;
                    end
                end
                ST_FIN: begin
                    r_ax    <= n_ax;
                    r_ay    <= n_ay;
                    r_zero  <= (w_iw == '0) || (w_ih == '0) || (w_sw == '0) || (w_sh == '0);
                    r_state <= ST_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_geom.ready = (r_state == ST_IDLE);
    assign o_geom.zero  = r_zero;
    assign o_geom.ax    = r_ax;
    assign o_geom.ay    = r_ay;

endmodule

// ===== src/wscm_cell.sv =====
// ----------------------------------------------------------------------------
// wscm_cell
// One stage of the division chain: develops one quotient bit for each axis
// and passes the partial result to the next cell.
// ----------------------------------------------------------------------------
module wscm_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [wscm_pkg::DIM_W-1:0] i_den_x,
    input  logic [wscm_pkg::DIM_W-1:0] i_den_y,
    input  wscm_pkg::t_lane            i_lane,
    output wscm_pkg::t_lane            o_lane
);

    localparam int DW = wscm_pkg::DIM_W;
    localparam int NW = wscm_pkg::NUM_W;

    wscm_pkg::t_lane r_lane;
    wscm_pkg::t_lane n_lane;
    logic [DW:0]     w_sx, w_sy;

    assign w_sx = wscm_pkg::div_step(i_lane.rem_x, i_lane.acc_x[NW-1], i_den_x);
    assign w_sy = wscm_pkg::div_step(i_lane.rem_y, i_lane.acc_y[NW-1], i_den_y);

    always_comb begin
        n_lane       = i_lane;
        n_lane.acc_x = {i_lane.acc_x[NW-2:0], w_sx[DW]};
        n_lane.rem_x = w_sx[DW-1:0];
        n_lane.acc_y = {i_lane.acc_y[NW-2:0], w_sy[DW]};
        n_lane.rem_y = w_sy[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule
